[hw/rtl/pip_pkg.sv]
// Shared constants, command codes and link types for the point-in-polygon block.
// Used by every module under hw/rtl; depends on nothing.
package pip_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int COORD_BITS   = 16;

	localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
	localparam int IDX_W  = $clog2(MAX_VERTICES);
	localparam int DIFF_W = COORD_BITS + 1;
	localparam int PROD_W = 2 * DIFF_W + 2;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_QUERY  = 2'd2;

	// one edge handed to the crossing unit
	typedef struct packed {
		logic                         vld;
		logic signed [COORD_BITS-1:0] x1;
		logic signed [COORD_BITS-1:0] y1;
		logic signed [COORD_BITS-1:0] x2;
		logic signed [COORD_BITS-1:0] y2;
		logic signed [COORD_BITS-1:0] px;
		logic signed [COORD_BITS-1:0] py;
	} edge_req_t;

	typedef struct packed {
		logic vld;
		logic crossed;
	} edge_res_t;

endpackage

[hw/rtl/pip_cell.sv]
// One vertex cell of the rotating vertex chain.
// Loads on append, hands its vertex to the neighbor on every shift. Uses pip_pkg.
module pip_cell (
	input  logic                                  clk,
	input  logic                                  load,
	input  logic                                  shift,
	input  logic signed [pip_pkg::COORD_BITS-1:0] ld_x,
	input  logic signed [pip_pkg::COORD_BITS-1:0] ld_y,
	input  logic signed [pip_pkg::COORD_BITS-1:0] nb_x,
	input  logic signed [pip_pkg::COORD_BITS-1:0] nb_y,
	output logic signed [pip_pkg::COORD_BITS-1:0] x,
	output logic signed [pip_pkg::COORD_BITS-1:0] y
);

	logic signed [pip_pkg::COORD_BITS-1:0] x_q;
	logic signed [pip_pkg::COORD_BITS-1:0] y_q;

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= ld_x;
			y_q <= ld_y;
		end else if (shift) begin
			x_q <= nb_x;
			y_q <= nb_y;
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

[hw/rtl/pip_edge.sv]
// Pipelined edge crossing test: one edge per cycle, two register stages.
// Compares the truncated crossing quotient by cross-multiplication. Uses pip_pkg.
module pip_edge (
	input  logic               clk,
	input  logic               arst_n,
	input  pip_pkg::edge_req_t req,
	output pip_pkg::edge_res_t res
);

	localparam int DW = pip_pkg::DIFF_W;
	localparam int PW = pip_pkg::PROD_W;

	logic signed [DW-1:0] den;
	logic signed [DW-1:0] dy1;
	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dpx;
	logic signed [DW:0]   dy_adj;
	logic signed [DW-1:0] dabs;
	logic                 skip;

	logic                 vld_s1;
	logic                 skip_s1;
	logic signed [DW:0]   dy_s1;
	logic signed [DW-1:0] dx_s1;
	logic signed [DW-1:0] dpx_s1;
	logic signed [DW-1:0] dabs_s1;

	logic signed [2*DW:0]   n_full;
	logic signed [2*DW-1:0] m_full;

	logic                 vld_s2;
	logic                 skip_s2;
	logic signed [PW-1:0] n_s2;
	logic signed [PW-1:0] m_s2;
	logic signed [PW-1:0] dabs_s2;
	logic                 hit;

	assign den = DW'(req.y2) - DW'(req.y1);
	assign dy1 = DW'(req.py) - DW'(req.y1);
	assign dx  = DW'(req.x2) - DW'(req.x1);
	assign dpx = DW'(req.px) - DW'(req.x1);

	// fold the sign of the denominator into the numerator
	assign dy_adj = den[DW-1] ? -((DW+1)'(dy1)) : (DW+1)'(dy1);
	assign dabs   = den[DW-1] ? -den : den;

	assign skip = (req.y1 > req.py && req.y2 > req.py) ||
		(req.y1 < req.py && req.y2 < req.py) ||
		(req.x1 < req.px && req.x2 < req.px) ||
		(den == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		skip_s1 <= skip;
		dy_s1   <= dy_adj;
		dx_s1   <= dx;
		dpx_s1  <= dpx;
		dabs_s1 <= dabs;
	end

	assign n_full = (2*DW+1)'(dy_s1) * (2*DW+1)'(dx_s1);
	assign m_full = (2*DW)'(dpx_s1) * (2*DW)'(dabs_s1);

	always_ff @(posedge clk) begin
		skip_s2 <= skip_s1;
		n_s2    <= PW'(n_full);
		m_s2    <= PW'(m_full);
		dabs_s2 <= PW'(dabs_s1);
	end

	// trunc(n/D) >= d: floor case n >= d*D, ceil case n > (d-1)*D
	always_comb begin
		if (!n_s2[PW-1])
			hit = (n_s2 >= m_s2);
		else
			hit = (n_s2 > (m_s2 - dabs_s2));
	end

	assign res.vld     = vld_s2;
	assign res.crossed = vld_s2 && !skip_s2 && hit;

endmodule

[hw/rtl/point_in_polygon_ray_cast.sv]
// Point-in-polygon (crossing number) top level: vertex chain, control and result register.
// Depends on pip_pkg, pip_cell and pip_edge.
//
// Clear and append are taken in ST_IDLE and leave the block there. A query transfer moves
// it through ST_RUN, ST_DRAIN and ST_FIN; result_valid rises as it returns to ST_IDLE, and
// the input is ready again in that same cycle, so a new query is taken only after the last
// has finished: the vertex chain rotates once around, one edge per cycle into the crossing
// pipeline, then the pipeline drains and the output register is loaded. The length of the
// run is set by the full rotation, which returns the chain to its original order, and does
// not depend on how many vertices are stored. Input is taken only between items; a
// finished result sits in an output register, so the next item can start while it waits.
// A query finishing while an earlier result still waits holds the input until it is taken.
module point_in_polygon_ray_cast (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  item_valid,
	output logic                                  item_ready,
	input  logic [1:0]                            command,
	input  logic signed [pip_pkg::COORD_BITS-1:0] coord_x,
	input  logic signed [pip_pkg::COORD_BITS-1:0] coord_y,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output logic                                  inside_res,
	output logic                                  vertex_overflow
);

	localparam int N  = pip_pkg::MAX_VERTICES;
	localparam int CW = pip_pkg::COORD_BITS;
	localparam int NW = pip_pkg::CNT_W;
	localparam int IW = pip_pkg::IDX_W;
	localparam int DRAIN_CYCLES = 2;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0]    state_q;
	logic [IW-1:0] step_q;
	logic [NW-1:0] cnt_q;
	logic          ovf_flag_q;
	logic          parity_q;
	logic          res_vld_q;
	logic          inside_q;
	logic          ovf_out_q;

	logic signed [CW-1:0] pt_x_q;
	logic signed [CW-1:0] pt_y_q;
	logic signed [CW-1:0] first_x_q;
	logic signed [CW-1:0] first_y_q;

	logic signed [CW-1:0] cell_x [N];
	logic signed [CW-1:0] cell_y [N];
	logic [N-1:0]         load_en;

	logic xfer;
	logic append_go;
	logic shift;
	logic last_edge;
	logic out_free;

	pip_pkg::edge_req_t req;
	pip_pkg::edge_res_t res;

	assign item_ready = (state_q == ST_IDLE);
	assign xfer       = item_valid && item_ready;
	assign append_go  = xfer && (command == pip_pkg::CMD_APPEND) && (cnt_q < NW'(N));
	assign shift      = (state_q == ST_RUN);

	for (genvar k = 0; k < N; k++) begin : g_cell
		localparam int NB = (k == N - 1) ? 0 : k + 1;

		assign load_en[k] = append_go && (cnt_q == NW'(k));

		pip_cell u_cell (
			.clk   (clk),
			.load  (load_en[k]),
			.shift (shift),
			.ld_x  (coord_x),
			.ld_y  (coord_y),
			.nb_x  (cell_x[NB]),
			.nb_y  (cell_y[NB]),
			.x     (cell_x[k]),
			.y     (cell_y[k])
		);
	end

	// cell 0 holds the edge start; the closing edge goes back to the saved first vertex
	assign last_edge = ((NW'(step_q) + NW'(1)) == cnt_q);

	always_comb begin
		req.vld = (state_q == ST_RUN) && (NW'(step_q) < cnt_q);
		req.x1  = cell_x[0];
		req.y1  = cell_y[0];
		req.x2  = last_edge ? first_x_q : cell_x[1];
		req.y2  = last_edge ? first_y_q : cell_y[1];
		req.px  = pt_x_q;
		req.py  = pt_y_q;
	end

	pip_edge u_edge (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.res    (res)
	);

	assign out_free = !res_vld_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			step_q     <= '0;
			cnt_q      <= '0;
			ovf_flag_q <= 1'b0;
			parity_q   <= 1'b0;
			res_vld_q  <= 1'b0;
		end else begin
			// in ST_FIN the output register is reloaded instead
			if (res_vld_q && result_ready && state_q != ST_FIN)
				res_vld_q <= 1'b0;
			if (res.vld && res.crossed)
				parity_q <= ~parity_q;

			case (state_q)
				ST_IDLE: begin
					if (xfer) begin
						case (command)
							pip_pkg::CMD_CLEAR: begin
								cnt_q      <= '0;
								ovf_flag_q <= 1'b0;
							end
							pip_pkg::CMD_APPEND: begin
								if (cnt_q < NW'(N))
									cnt_q <= cnt_q + NW'(1);
								else
									ovf_flag_q <= 1'b1;
							end
							pip_pkg::CMD_QUERY: begin
								parity_q <= 1'b0;
								step_q   <= '0;
								state_q  <= ST_RUN;
							end
							default: ;
						endcase
					end
				end
				ST_RUN: begin
					if (step_q == IW'(N - 1)) begin
						step_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + IW'(1);
					end
				end
				ST_DRAIN: begin
					if (step_q == IW'(DRAIN_CYCLES - 1)) begin
						step_q  <= '0;
						state_q <= ST_FIN;
					end else begin
						step_q <= step_q + IW'(1);
					end
				end
				ST_FIN: begin
					if (out_free) begin
						res_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (xfer && command == pip_pkg::CMD_QUERY) begin
			pt_x_q    <= coord_x;
			pt_y_q    <= coord_y;
			first_x_q <= cell_x[0];
			first_y_q <= cell_y[0];
		end
		if (state_q == ST_FIN && out_free) begin
			inside_q  <= parity_q;
			ovf_out_q <= ovf_flag_q;
		end
	end

	assign result_valid    = res_vld_q;
	assign inside_res      = inside_q;
	assign vertex_overflow = ovf_out_q;

endmodule

[hw/rtl/pip_checker.sv]
// Port-level checks for point_in_polygon_ray_cast, bound to the top level.
// Depends on pip_pkg.
module pip_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  item_valid,
	input logic                                  item_ready,
	input logic [1:0]                            command,
	input logic signed [pip_pkg::COORD_BITS-1:0] coord_x,
	input logic signed [pip_pkg::COORD_BITS-1:0] coord_y,
	input logic                                  result_valid,
	input logic                                  result_ready,
	input logic                                  inside_res,
	input logic                                  vertex_overflow
);

	logic xfer;
	assign xfer = item_valid && item_ready;

	// a stalled result holds its value
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=>
			result_valid && $stable(inside_res) && $stable(vertex_overflow))
		else $error("result changed while stalled");

	// a query occupies the block: no new item on the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && command == pip_pkg::CMD_QUERY |=> !item_ready)
		else $error("item taken during a query");

	// clear and append never produce a result
	a_silent: assert property (@(posedge clk) disable iff (!arst_n)
		xfer && (command == pip_pkg::CMD_CLEAR || command == pip_pkg::CMD_APPEND)
			|=> !$rose(result_valid))
		else $error("result after a non-query item");

	// a result appears only once the block is free again
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> item_ready && !$past(item_ready))
		else $error("result outside query completion");

endmodule

bind point_in_polygon_ray_cast pip_checker u_pip_checker (.*);
